/* rtl/pes_hdr_pkg.sv */
// ----------------------------------------------------------------------------
// pes_hdr_pkg
// Types, codes and helper functions shared by the PES header parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package pes_hdr_pkg;

  // widths of the record fields
  localparam int unsigned PosW = 9;
  localparam int unsigned TsW  = 33;
  localparam logic [PosW-1:0] PosMax = '1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_START     = 3'd1,
    ERR_MARKER    = 3'd2,
    ERR_SHORT     = 3'd3,
    ERR_HDR_LEN   = 3'd4
  } err_e;

  // parse phases
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_e;

  // fixed header positions and codes
  localparam logic [PosW-1:0] PosStreamId  = 9'd3;
  localparam logic [PosW-1:0] PosShortEnd  = 9'd5;
  localparam logic [PosW-1:0] PosMarker    = 9'd6;
  localparam logic [PosW-1:0] PosFlags     = 9'd7;
  localparam logic [PosW-1:0] PosHdrLen    = 9'd8;
  localparam logic [PosW-1:0] PosTsFirst   = 9'd9;
  localparam logic [1:0]      MarkerBits   = 2'b10;
  localparam logic [3:0]      TsBytes      = 4'd5;

  // one result item
  typedef struct packed {
    kind_e           kind;
    logic [7:0]      payload_byte;
    logic [7:0]      stream_kind_id;
    logic            extended_header;
    logic            pts_present;
    logic [TsW-1:0]  pts_value;
    logic            dts_present;
    logic [TsW-1:0]  dts_value;
    err_e            error_code;
    logic            end_of_packet;
  } result_t;

  // stream ids that use the short six-byte header
  function automatic logic is_short_id(input logic [7:0] id);
    return id inside {8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hFF, 8'hF2, 8'hF8};
  endfunction

  // bits contributed by one of the five timestamp bytes
  function automatic logic [TsW-1:0] ts_part(input logic [2:0] k, input logic [7:0] b);
    logic [TsW-1:0] v;
    v = '0;
    case (k)
      3'd0:    v[32:30] = b[3:1];
      3'd1:    v[29:22] = b;
      3'd2:    v[21:15] = b[7:1];
      3'd3:    v[14:7]  = b;
      default: v[6:0]   = b[7:1];
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/pes_hdr_if.sv */
// ----------------------------------------------------------------------------
// pes_in_if / pes_out_if
// Valid/ready channels for packet bytes in and parser results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

interface pes_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [7:0]  stream_kind_id;
  logic        extended_header;
  logic        pts_present;
  logic [32:0] pts_value;
  logic        dts_present;
  logic [32:0] dts_value;
  logic [2:0]  error_code;
  logic        end_of_packet;

  modport source (
    output valid, output kind, output payload_byte, output stream_kind_id,
    output extended_header, output pts_present, output pts_value,
    output dts_present, output dts_value, output error_code,
    output end_of_packet, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input stream_kind_id,
    input extended_header, input pts_present, input pts_value,
    input dts_present, input dts_value, input error_code,
    input end_of_packet, output ready
  );
endinterface

`default_nettype wire

/* rtl/pes_hdr_core.sv */
// ----------------------------------------------------------------------------
// pes_hdr_core
// Header state registers and the per-byte parse logic that builds a result.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_hdr_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                packet_end_i,
  output logic                     res_valid_o,
  output pes_hdr_pkg::result_t     res_o
);
  import pes_hdr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      sid_q, sid_d;
  logic            ext_q, ext_d;
  logic [1:0]      tsf_q, tsf_d;
  logic [7:0]      hdl_q, hdl_d;
  logic [TsW-1:0]  pts_q, pts_d;
  logic [TsW-1:0]  dts_q, dts_d;

  logic            first;
  phase_e          phase_e_cur;
  logic [PosW-1:0] k;
  logic [PosW-1:0] k_dts;
  logic [3:0]      need;
  logic            header_done;
  err_e            err;

  assign first = (pos_q == '0);
  assign k     = pos_q - PosTsFirst;
  assign k_dts = k - PosW'(TsBytes);

  // parse one byte
  always_comb begin
    phase_e_cur = first ? PH_HEADER : phase_q;
    sid_d       = first ? '0 : sid_q;
    ext_d       = first ? 1'b0 : ext_q;
    tsf_d       = first ? '0 : tsf_q;
    hdl_d       = first ? '0 : hdl_q;
    pts_d       = first ? '0 : pts_q;
    dts_d       = first ? '0 : dts_q;
    need        = (tsf_d[1] ? TsBytes : 4'd0) + (tsf_d[0] ? TsBytes : 4'd0);
    header_done = 1'b0;
    err         = ERR_NONE;

    if (phase_e_cur == PH_HEADER) begin
      if (pos_q < PosStreamId) begin
        if (data_byte_i != ((pos_q == 9'd2) ? 8'h01 : 8'h00)) begin
          err = ERR_START;
        end
      end else if (pos_q == PosStreamId) begin
        sid_d = data_byte_i;
        ext_d = ~is_short_id(data_byte_i);
      end else if (pos_q == PosShortEnd) begin
        header_done = ~ext_d;
      end else if (pos_q == PosMarker) begin
        if (data_byte_i[7:6] != MarkerBits) begin
          err = ERR_MARKER;
        end
      end else if (pos_q == PosFlags) begin
        tsf_d = data_byte_i[7:6];
      end else if (pos_q == PosHdrLen) begin
        hdl_d = data_byte_i;
        if (data_byte_i < {4'd0, need}) begin
          err = ERR_HDR_LEN;
        end else if (data_byte_i == 8'd0) begin
          header_done = 1'b1;
        end
      end else if (pos_q > PosHdrLen) begin
        // timestamp bytes, pts first
        if (tsf_d[1]) begin
          if (k < PosW'(TsBytes)) begin
            pts_d = pts_d | ts_part(k[2:0], data_byte_i);
          end else if (k < PosW'(2 * TsBytes) && tsf_d[0]) begin
            dts_d = dts_d | ts_part(k_dts[2:0], data_byte_i);
          end
        end else if (tsf_d[0] && k < PosW'(TsBytes)) begin
          dts_d = dts_d | ts_part(k[2:0], data_byte_i);
        end
        header_done = (pos_q == PosHdrLen + {1'b0, hdl_d});
      end
      if (err == ERR_NONE && !header_done && packet_end_i) begin
        err = ERR_SHORT;
      end
    end
  end

  // result and next phase
  always_comb begin
    res_o        = '0;
    res_o.kind   = KIND_PAYLOAD;
    res_o.error_code = ERR_NONE;
    res_valid_o  = 1'b0;
    phase_d      = phase_e_cur;
    case (phase_e_cur)
      PH_PAYLOAD: begin
        res_valid_o        = 1'b1;
        res_o.payload_byte = data_byte_i;
      end
      PH_HEADER: begin
        if (err != ERR_NONE) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_ERROR;
          res_o.error_code = err;
          phase_d          = PH_DROP;
        end else if (header_done) begin
          res_valid_o           = 1'b1;
          res_o.kind            = KIND_HEADER;
          res_o.stream_kind_id  = sid_d;
          res_o.extended_header = ext_d;
          res_o.pts_present     = tsf_d[1];
          res_o.pts_value       = tsf_d[1] ? pts_d : '0;
          res_o.dts_present     = tsf_d[0];
          res_o.dts_value       = tsf_d[0] ? dts_d : '0;
          phase_d               = PH_PAYLOAD;
        end
      end
      default: begin
        phase_d = phase_e_cur;
      end
    endcase
    res_o.end_of_packet = res_valid_o & packet_end_i;
    if (packet_end_i) begin
      phase_d = PH_HEADER;
    end
    if (packet_end_i) begin
      pos_d = '0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_HEADER;
      sid_q   <= '0;
      ext_q   <= 1'b0;
      tsf_q   <= '0;
      hdl_q   <= '0;
      pts_q   <= '0;
      dts_q   <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      sid_q   <= sid_d;
      ext_q   <= ext_d;
      tsf_q   <= tsf_d;
      hdl_q   <= hdl_d;
      pts_q   <= pts_d;
      dts_q   <= dts_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/pes_hdr_out.sv */
// ----------------------------------------------------------------------------
// pes_hdr_out
// Result register; frees itself in the same cycle the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_hdr_out (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic                res_valid_i,
  input  wire pes_hdr_pkg::result_t res_i,
  input  wire logic                out_ready_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output pes_hdr_pkg::result_t     out_data_o
);
  import pes_hdr_pkg::*;

  logic    valid_q;
  result_t data_q;

  // room when empty or draining this cycle
  assign in_ready_o  = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/pes_header_parser.sv */
// ----------------------------------------------------------------------------
// pes_header_parser
// MPEG-2 PES header parser: one packet byte in, at most one result out.
//
// in_i carries one packet byte per transaction with packet_end on the last
// byte; the next byte opens a new packet. out_o carries results:
// a header record when the header is complete, then one transaction per
// payload byte, or a single error record after which the packet is dropped.
// A byte is parsed in the cycle it is taken and its result is registered,
// so a result shows in the cycle after its byte. One byte is taken every cycle
// while the result register is empty or being read in that same cycle;
// the throughput is one byte per cycle, set by the result register alone.
// When the receiver stalls, the pending result holds and in_i.ready drops
// until it is taken. Reset clears all header state and the result register;
// the first byte after reset is byte 0 of a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module pes_header_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pes_in_if.sink    in_i,
  pes_out_if.source out_o
);
  import pes_hdr_pkg::*;

  logic    accept;
  logic    in_ready;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid & in_ready;

  // byte parser and header state
  pes_hdr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (in_i.data_byte),
    .packet_end_i (in_i.packet_end),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result register
  pes_hdr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_data)
  );

  // unpack result fields
  assign out_o.kind            = out_data.kind;
  assign out_o.payload_byte    = out_data.payload_byte;
  assign out_o.stream_kind_id  = out_data.stream_kind_id;
  assign out_o.extended_header = out_data.extended_header;
  assign out_o.pts_present     = out_data.pts_present;
  assign out_o.pts_value       = out_data.pts_value;
  assign out_o.dts_present     = out_data.dts_present;
  assign out_o.dts_value       = out_data.dts_value;
  assign out_o.error_code      = out_data.error_code;
  assign out_o.end_of_packet   = out_data.end_of_packet;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PES header parser. Packet bytes go in on a
// valid/ready channel, and a byte-level parser model inside the bench
// predicts every result. Stimulus is a short directed set followed by
// random packets: mostly well-formed, some broken, some noise. Both sides
// insert idle bursts, the receiver holds off once for a long stretch, and
// every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pes_hdr_pkg::*;

  // one byte waiting to be sent
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // packet shapes the generator can build
  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_START,
    SHAPE_BAD_MARKER,
    SHAPE_LEN_SHORT,
    SHAPE_TRUNCATED,
    SHAPE_NOISE
  } shape_e;

  localparam logic [7:0] ShortIds [8] = '{8'hBC, 8'hBE, 8'hBF, 8'hF0,
                                          8'hF1, 8'hFF, 8'hF2, 8'hF8};
  localparam int HoldAt  = 400;
  localparam int HoldLen = 60;

  logic clk;
  logic rst_ni;

  pes_in_if  in_if ();
  pes_out_if out_if ();

  pes_header_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  byte_item_t pending_bytes [$];
  result_t    expected_results [$];
  byte_item_t tx_item;
  result_t    want_rec;
  int         bytes_queued = 0;
  int         bytes_taken;
  int         mismatches = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         hold_count;
  logic       rx_hold;

  // parser state mirrored by the bench
  logic [PosW-1:0] pes_pos = '0;
  phase_e          pes_phase = PH_HEADER;
  logic [7:0]      pes_sid = '0;
  logic            pes_ext = 1'b0;
  logic [1:0]      pes_flags = '0;
  logic [7:0]      pes_len = '0;
  logic [TsW-1:0]  pes_pts = '0;
  logic [TsW-1:0]  pes_dts = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // reset and known input levels from time zero
  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.packet_end = 1'b0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic short_header_id(input logic [7:0] id);
    case (id)
      8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hFF, 8'hF2, 8'hF8: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // timestamp bits carried by header data byte k of a five-byte group
  function automatic logic [TsW-1:0] stamp_bits(input int k, input logic [7:0] b);
    logic [TsW-1:0] w;
    w = TsW'(b);
    case (k)
      0: return (w & 33'h0E) << 29;
      1: return w << 22;
      2: return (w & 33'hFE) << 14;
      3: return w << 7;
      default: return (w & 33'hFE) >> 1;
    endcase
  endfunction

  // advance the parser by one byte and queue the result it causes
  task automatic parse_byte(input logic [7:0] b, input logic last);
    result_t rec;
    logic    emit;
    logic    done;
    err_e    err;
    int      pos;
    int      k;
    int      need;
    pos = int'(pes_pos);
    rec = '0;
    emit = 1'b0;
    done = 1'b0;
    err = ERR_NONE;
    if (pos == 0) begin
      pes_phase = PH_HEADER;
      pes_sid = '0;
      pes_ext = 1'b0;
      pes_flags = '0;
      pes_len = '0;
      pes_pts = '0;
      pes_dts = '0;
    end
    case (pes_phase)
      PH_PAYLOAD: begin
        rec.kind = KIND_PAYLOAD;
        rec.payload_byte = b;
        emit = 1'b1;
      end
      PH_HEADER: begin
        if (pos <= 2) begin
          if (b != ((pos == 2) ? 8'h01 : 8'h00)) err = ERR_START;
        end else if (pos == 3) begin
          pes_sid = b;
          pes_ext = !short_header_id(b);
        end else if (pos == 4) begin
          // packet length high byte carries no meaning here
        end else if (pos == 5) begin
          done = !pes_ext;
        end else if (pos == 6) begin
          if (b[7:6] != MarkerBits) err = ERR_MARKER;
        end else if (pos == 7) begin
          pes_flags = b[7:6];
        end else if (pos == 8) begin
          need = (pes_flags[1] ? 5 : 0) + (pes_flags[0] ? 5 : 0);
          pes_len = b;
          if (int'(b) < need) err = ERR_HDR_LEN;
          else if (b == 8'h00) done = 1'b1;
        end else begin
          // pts first, dts after it, or dts alone when only its flag is set
          k = pos - 9;
          if (pes_flags[1]) begin
            if (k < 5) pes_pts |= stamp_bits(k, b);
            else if (k < 10 && pes_flags[0]) pes_dts |= stamp_bits(k - 5, b);
          end else if (pes_flags[0] && k < 5) begin
            pes_dts |= stamp_bits(k, b);
          end
          if (pos == 8 + int'(pes_len)) done = 1'b1;
        end
        if (err == ERR_NONE && !done && last) err = ERR_SHORT;
        if (err != ERR_NONE) begin
          rec.kind = KIND_ERROR;
          rec.error_code = err;
          emit = 1'b1;
          pes_phase = PH_DROP;
        end else if (done) begin
          rec.kind = KIND_HEADER;
          rec.stream_kind_id = pes_sid;
          rec.extended_header = pes_ext;
          rec.pts_present = pes_flags[1];
          rec.pts_value = pes_flags[1] ? pes_pts : '0;
          rec.dts_present = pes_flags[0];
          rec.dts_value = pes_flags[0] ? pes_dts : '0;
          emit = 1'b1;
          pes_phase = PH_PAYLOAD;
        end
      end
      default: begin
        // dropped bytes give nothing
      end
    endcase
    if (emit) begin
      rec.end_of_packet = last;
      expected_results.push_back(rec);
    end
    if (last) begin
      pes_pos = '0;
      pes_phase = PH_HEADER;
    end else if (pes_pos != PosMax) begin
      pes_pos = pes_pos + 1'b1;
    end
  endtask

  function automatic void compare_field(input string name, input logic [TsW-1:0] want,
                                        input logic [TsW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic queue_bytes(input logic [7:0] pkt [$]);
    foreach (pkt[i]) pending_bytes.push_back('{data: pkt[i], last: (i == pkt.size() - 1)});
    bytes_queued += pkt.size();
  endtask

  // build one packet of the given shape and queue its bytes
  task automatic add_packet(input shape_e shape, input int payload_len);
    logic [7:0] pkt [$];
    logic [7:0] sid;
    logic [1:0] flags;
    logic [1:0] mark;
    int         need;
    int         len;
    int         hdr_size;
    int         j;
    int         cut;
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
    end else begin
      if (shape == SHAPE_BAD_MARKER || shape == SHAPE_LEN_SHORT) begin
        do sid = 8'($urandom); while (short_header_id(sid));
      end else if ($urandom_range(0, 3) == 0) begin
        sid = ShortIds[$urandom_range(0, 7)];
      end else begin
        sid = 8'($urandom);
      end
      pkt = {8'h00, 8'h00, 8'h01, sid, 8'($urandom), 8'($urandom)};
      hdr_size = 6;
      if (!short_header_id(sid)) begin
        flags = (shape == SHAPE_LEN_SHORT) ? 2'($urandom_range(1, 3)) : 2'($urandom);
        need = (flags[1] ? 5 : 0) + (flags[0] ? 5 : 0);
        len = ($urandom_range(0, 3) == 0) ? need + $urandom_range(1, 6) : need;
        if (shape == SHAPE_LEN_SHORT) len = $urandom_range(0, need - 1);
        mark = MarkerBits;
        if (shape == SHAPE_BAD_MARKER) begin
          mark = 2'($urandom_range(0, 2));
          if (mark == MarkerBits) mark = 2'b11;
        end
        pkt.push_back({mark, 6'($urandom)});
        pkt.push_back({flags, 6'($urandom)});
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom));
        hdr_size = 9 + len;
      end
      repeat (payload_len) pkt.push_back(8'($urandom));
      if (shape == SHAPE_BAD_START) begin
        j = $urandom_range(0, 2);
        pkt[j] = pkt[j] ^ 8'($urandom_range(1, 255));
      end
      if (shape == SHAPE_TRUNCATED) begin
        cut = $urandom_range(0, hdr_size - 2);
        pkt = pkt[0:cut];
      end
    end
    queue_bytes(pkt);
  endtask

  // byte driver: predict on every accepted transaction, then offer the next
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= '0;
      in_if.packet_end <= 1'b0;
      bytes_taken <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.data_byte, in_if.packet_end);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
          tx_gap = $urandom_range(0, 3);
          in_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          tx_item = pending_bytes.pop_front();
          in_if.valid <= 1'b1;
          in_if.data_byte <= tx_item.data;
          in_if.packet_end <= tx_item.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off once enough bytes have gone in
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold <= 1'b0;
      hold_count <= 0;
    end else if (bytes_taken >= HoldAt && hold_count < HoldLen) begin
      rx_hold <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      rx_hold <= 1'b0;
    end
  end

  // receiver ready with random stall bursts
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (rx_hold) begin
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_gap = $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: kind %0d", out_if.kind);
        mismatches++;
      end else begin
        want_rec = expected_results.pop_front();
        compare_field("kind", TsW'(want_rec.kind), TsW'(out_if.kind));
        compare_field("payload_byte", TsW'(want_rec.payload_byte), TsW'(out_if.payload_byte));
        compare_field("stream_kind_id", TsW'(want_rec.stream_kind_id),
                      TsW'(out_if.stream_kind_id));
        compare_field("extended_header", TsW'(want_rec.extended_header),
                      TsW'(out_if.extended_header));
        compare_field("pts_present", TsW'(want_rec.pts_present), TsW'(out_if.pts_present));
        compare_field("pts_value", want_rec.pts_value, out_if.pts_value);
        compare_field("dts_present", TsW'(want_rec.dts_present), TsW'(out_if.dts_present));
        compare_field("dts_value", want_rec.dts_value, out_if.dts_value);
        compare_field("error_code", TsW'(want_rec.error_code), TsW'(out_if.error_code));
        compare_field("end_of_packet", TsW'(want_rec.end_of_packet),
                      TsW'(out_if.end_of_packet));
      end
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // stimulus
  initial begin
    logic [7:0] pkt [$];
    int         chunk_start;
    int         pick;
    int         payload_len;
    logic       long_done;
    shape_e     shape;
    long_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk);

    // directed: short header ending on the payload, start code fault,
    // empty extended header ending on its length byte, marker fault on the last byte
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pkt = {8'h00, 8'h00, 8'h01, 8'hFF, 8'h12, 8'h34, 8'hFF, 8'h00};
    queue_bytes(pkt);
    pkt = {8'h00, 8'h07};
    queue_bytes(pkt);
    pkt = {8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00};
    queue_bytes(pkt);
    pkt = {8'h00, 8'h00, 8'h01, 8'hC0, 8'hFF, 8'hFF, 8'h40};
    queue_bytes(pkt);
    wait_drained();

    // random packets in chunks, each chunk with its own idle mix
    while (bytes_queued < 1050) begin
      tx_idle_pct = 15 * $urandom_range(0, 3);
      rx_idle_pct = 15 * $urandom_range(0, 3);
      chunk_start = bytes_queued;
      while (bytes_queued - chunk_start < 100) begin
        if (!long_done && bytes_queued >= 500) begin
          // long enough for the byte position to saturate
          add_packet(SHAPE_GOOD, 520);
          long_done = 1'b1;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 62) shape = SHAPE_GOOD;
          else if (pick < 70) shape = SHAPE_BAD_START;
          else if (pick < 77) shape = SHAPE_BAD_MARKER;
          else if (pick < 84) shape = SHAPE_LEN_SHORT;
          else if (pick < 93) shape = SHAPE_TRUNCATED;
          else shape = SHAPE_NOISE;
          payload_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
          add_packet(shape, payload_len);
        end
      end
      while (pending_bytes.size() != 0) @(negedge clk);
    end

    // closing stretch at full rate
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    chunk_start = bytes_queued;
    while (bytes_queued - chunk_start < 150)
      add_packet(SHAPE_GOOD, $urandom_range(0, 16));
    wait_drained();
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
